/* hdl/grf_pkg.sv */
// Shared constants, register codes and control structs for the gradient fill unit.
`timescale 1ns / 1ps

package grf_pkg;

  // Surface geometry
  localparam int SURF_W   = 1024;
  localparam int SURF_H   = 1024;
  localparam int SURF_MAX = (SURF_W > SURF_H) ? SURF_W : SURF_H;

  // Coordinate and length width: holds 0..SURF_MAX
  localparam int LW = $clog2(SURF_MAX + 1);

  // Field widths
  localparam int RECT_W    = 12;
  localparam int COLOR_W   = 32;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = COLOR_W / CH_W;
  localparam int ADDR_W    = 20;
  localparam int CFG_IDX_W = 3;

  // Linear address width before wrapping to ADDR_W
  localparam int LIN_W = (2 * LW + 1 > ADDR_W) ? 2 * LW + 1 : ADDR_W;

  // Line color divider: numerator c1*(n-i)+c2*i stays below 2^CH_W * n
  localparam int NUM_W     = CH_W + LW;
  localparam int DIV_STEPS = CH_W;
  localparam int DIV_K_W   = $clog2(DIV_STEPS);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_X,
    REG_RECT_Y,
    REG_RECT_W,
    REG_RECT_H,
    REG_COLOR_START,
    REG_COLOR_END,
    REG_GRAD_VERT
  } reg_idx_t;

  // Controller to datapath commands
  typedef struct packed {
    logic               clip;
    logic               emit;
    logic               num;
    logic               div;
    logic [DIV_K_W-1:0] div_k;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic active;
    logic wrap;
    logic cancel;
    logic out_free;
  } stat_t;

endpackage

/* hdl/grf_ifs.sv */
// Valid/ready channel interfaces for the input, result and configuration ports.
`timescale 1ns / 1ps

interface grf_in_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

interface grf_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] pixel_address;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        last;

  modport source (output valid, output pixel_address, output red, output green,
                  output blue, output alpha, output last, input ready);
  modport sink (input valid, input pixel_address, input red, input green,
                input blue, input alpha, input last, output ready);
endinterface

interface grf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/grf_ctrl.sv */
// Fill sequencer: input handshake, first-pixel step and line color divider steps.
`timescale 1ns / 1ps

module grf_ctrl
  import grf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  grf_in_if.sink     in_if,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_NUM,
    S_DIV
  } state_t;

  state_t             state_r;
  logic [DIV_K_W-1:0] k_r;
  logic               accept;

  // Take a beat only when idle and the output register can take a pixel
  assign in_if.ready = (state_r == S_IDLE) && stat.out_free;
  assign accept      = in_if.valid && in_if.ready;

  // Decode commands
  always_comb begin
    cmd       = '0;
    cmd.div_k = k_r;
    case (state_r)
      S_IDLE: begin
        cmd.clip = accept && in_if.start_req;
        cmd.emit = accept && !in_if.start_req && stat.active;
      end
      S_FIRST: begin
        cmd.emit = stat.active && stat.out_free;
      end
      S_NUM: begin
        cmd.num = 1'b1;
      end
      S_DIV: begin
        cmd.div = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Advance state and divider step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else if (stat.cancel) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.clip) begin
            state_r <= S_FIRST;
          end else if (cmd.emit && stat.wrap) begin
            state_r <= S_NUM;
          end
        end
        S_FIRST: begin
          if (!stat.active) begin
            state_r <= S_IDLE;
          end else if (cmd.emit) begin
            state_r <= stat.wrap ? S_NUM : S_IDLE;
          end
        end
        S_NUM: begin
          state_r <= S_DIV;
          k_r     <= DIV_K_W'(DIV_STEPS - 1);
        end
        S_DIV: begin
          if (k_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r - 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/grf_dp.sv */
// Fill datapath: config registers, clipping, pixel walk, line divider and output register.
`timescale 1ns / 1ps

module grf_dp
  import grf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  grf_cfg_if.sink    cfg_if,
  grf_out_if.source  out_if,
  input  cmd_t       cmd,
  output stat_t      stat
);

  localparam logic signed [RECT_W:0] SURF_W_S = (RECT_W + 1)'(SURF_W);
  localparam logic signed [RECT_W:0] SURF_H_S = (RECT_W + 1)'(SURF_H);

  // Configuration registers
  logic [RECT_W-1:0]  rect_x_r;
  logic [RECT_W-1:0]  rect_y_r;
  logic [RECT_W-1:0]  rect_w_r;
  logic [RECT_W-1:0]  rect_h_r;
  logic [COLOR_W-1:0] color_start_r;
  logic [COLOR_W-1:0] color_end_r;
  logic               grad_vert_r;

  // Fill state
  logic               active_r;
  logic [LW-1:0]      outer_r;
  logic [LW-1:0]      inner_r;
  logic [LW-1:0]      cx0_r;
  logic [LW-1:0]      cy0_r;
  logic [LW-1:0]      cw_r;
  logic [LW-1:0]      ch_r;
  logic [COLOR_W-1:0] line_color_r;
  logic [NUM_W-1:0]   rem_r [NUM_CH];

  // Output register
  logic               out_valid_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [COLOR_W-1:0] color_r;
  logic               last_r;

  logic               cfg_hit;
  logic               out_free;

  logic signed [RECT_W:0] rx_s, ry_s;
  logic [LW-1:0]          x_clamp, y_clamp, w_clip, h_clip;
  logic [RECT_W:0]        x_sum, y_sum;
  logic                   nonempty;

  logic [LW-1:0]      on_len, in_len;
  logic [LW:0]        inner_inc, outer_inc;
  logic               last_c, wrap_c;
  logic [LW:0]        row_sum, col_sum;
  logic [LW-1:0]      row, col;
  logic [LIN_W-1:0]   lin;

  logic [LW-1:0]      n_minus_i;
  logic [NUM_W-1:0]   num_c   [NUM_CH];
  logic [NUM_W-1:0]   dsh;
  logic [NUM_W:0]     trial_c [NUM_CH];

  // Register write decode: only listed indexes take effect
  always_comb begin
    case (cfg_if.index)
      REG_RECT_X, REG_RECT_Y, REG_RECT_W, REG_RECT_H,
      REG_COLOR_START, REG_COLOR_END, REG_GRAD_VERT: cfg_hit = 1'b1;
      default:                                       cfg_hit = 1'b0;
    endcase
  end

  assign cfg_if.ready = 1'b1;

  // Clamp edges to the surface, cut sizes only on overflow
  always_comb begin
    rx_s = {rect_x_r[RECT_W-1], rect_x_r};
    ry_s = {rect_y_r[RECT_W-1], rect_y_r};

    if (rx_s < 0) begin
      x_clamp = '0;
    end else if (rx_s > SURF_W_S) begin
      x_clamp = LW'(SURF_W);
    end else begin
      x_clamp = rx_s[LW-1:0];
    end

    if (ry_s < 0) begin
      y_clamp = '0;
    end else if (ry_s > SURF_H_S) begin
      y_clamp = LW'(SURF_H);
    end else begin
      y_clamp = ry_s[LW-1:0];
    end

    x_sum = (RECT_W + 1)'(x_clamp) + (RECT_W + 1)'(rect_w_r);
    y_sum = (RECT_W + 1)'(y_clamp) + (RECT_W + 1)'(rect_h_r);
    w_clip = (x_sum > (RECT_W + 1)'(SURF_W)) ? LW'(SURF_W) - x_clamp : rect_w_r[LW-1:0];
    h_clip = (y_sum > (RECT_W + 1)'(SURF_H)) ? LW'(SURF_H) - y_clamp : rect_h_r[LW-1:0];
    nonempty = (w_clip != '0) && (h_clip != '0);
  end

  // Walk position, last flag and address
  always_comb begin
    on_len    = grad_vert_r ? ch_r : cw_r;
    in_len    = grad_vert_r ? cw_r : ch_r;
    inner_inc = (LW + 1)'(inner_r) + 1'b1;
    outer_inc = (LW + 1)'(outer_r) + 1'b1;
    last_c    = (inner_inc >= (LW + 1)'(in_len)) && (outer_inc >= (LW + 1)'(on_len));
    wrap_c    = !last_c && (inner_inc >= (LW + 1)'(in_len));

    if (grad_vert_r) begin
      row_sum = (LW + 1)'(cy0_r) + (LW + 1)'(outer_r);
      col_sum = (LW + 1)'(cx0_r) + (LW + 1)'(inner_r);
    end else begin
      row_sum = (LW + 1)'(cy0_r) + (LW + 1)'(inner_r);
      col_sum = (LW + 1)'(cx0_r) + (LW + 1)'(outer_r);
    end
    row = row_sum[LW-1:0];
    col = col_sum[LW-1:0];
    lin = LIN_W'(row) * LIN_W'(SURF_W) + LIN_W'(col);
  end

  // Per-channel numerators and one restoring divide step
  always_comb begin
    n_minus_i = on_len - outer_r;
    dsh       = NUM_W'(on_len) << cmd.div_k;
    for (int c = 0; c < NUM_CH; c++) begin
      num_c[c] = NUM_W'(color_start_r[c*CH_W +: CH_W]) * NUM_W'(n_minus_i)
               + NUM_W'(color_end_r[c*CH_W +: CH_W]) * NUM_W'(outer_r);
      trial_c[c] = {1'b0, rem_r[c]} - {1'b0, dsh};
    end
  end

  assign out_free = !out_valid_r || out_if.ready;

  assign stat.active   = active_r;
  assign stat.wrap     = wrap_c;
  assign stat.cancel   = cfg_if.valid && cfg_hit;
  assign stat.out_free = out_free;

  // Control, configuration and fill state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_x_r      <= '0;
      rect_y_r      <= '0;
      rect_w_r      <= '0;
      rect_h_r      <= '0;
      color_start_r <= '0;
      color_end_r   <= '0;
      grad_vert_r   <= 1'b0;
      active_r      <= 1'b0;
      outer_r       <= '0;
      inner_r       <= '0;
      cx0_r         <= '0;
      cy0_r         <= '0;
      cw_r          <= '0;
      ch_r          <= '0;
      line_color_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.index)
          REG_RECT_X:      rect_x_r      <= cfg_if.data[RECT_W-1:0];
          REG_RECT_Y:      rect_y_r      <= cfg_if.data[RECT_W-1:0];
          REG_RECT_W:      rect_w_r      <= cfg_if.data[RECT_W-1:0];
          REG_RECT_H:      rect_h_r      <= cfg_if.data[RECT_W-1:0];
          REG_COLOR_START: color_start_r <= cfg_if.data;
          REG_COLOR_END:   color_end_r   <= cfg_if.data;
          REG_GRAD_VERT:   grad_vert_r   <= cfg_if.data[0];
          default:         ;
        endcase
      end

      if (stat.cancel) begin
        // Drop any running fill
        active_r <= 1'b0;
        outer_r  <= '0;
        inner_r  <= '0;
      end else if (cmd.clip) begin
        // Latch clipped geometry; the first line is the start color itself
        cx0_r        <= x_clamp;
        cy0_r        <= y_clamp;
        cw_r         <= w_clip;
        ch_r         <= h_clip;
        outer_r      <= '0;
        inner_r      <= '0;
        active_r     <= nonempty;
        line_color_r <= nonempty ? color_start_r : '0;
      end else if (cmd.emit) begin
        if (last_c) begin
          active_r <= 1'b0;
          outer_r  <= '0;
          inner_r  <= '0;
        end else if (wrap_c) begin
          inner_r <= '0;
          outer_r <= outer_inc[LW-1:0];
        end else begin
          inner_r <= inner_inc[LW-1:0];
        end
      end else if (cmd.div) begin
        // Shift one quotient bit into each channel of the line color
        for (int c = 0; c < NUM_CH; c++) begin
          line_color_r[c*CH_W +: CH_W] <=
            {line_color_r[c*CH_W +: CH_W-1], !trial_c[c][NUM_W]};
        end
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Divider remainders and output payload
  always_ff @(posedge clk) begin
    if (cmd.num) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem_r[c] <= num_c[c];
      end
    end else if (cmd.div) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (!trial_c[c][NUM_W]) begin
          rem_r[c] <= trial_c[c][NUM_W-1:0];
        end
      end
    end

    if (cmd.emit) begin
      addr_r  <= lin[ADDR_W-1:0];
      color_r <= line_color_r;
      last_r  <= last_c;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.pixel_address = addr_r;
  assign out_if.red           = color_r[31:24];
  assign out_if.green         = color_r[23:16];
  assign out_if.blue          = color_r[15:8];
  assign out_if.alpha         = color_r[7:0];
  assign out_if.last          = last_r;

endmodule

/* hdl/gradient_rect_fill_unit.sv */
// Top level of the gradient rectangle fill unit: sequencer plus datapath.
// Timing: an advance beat's pixel is registered in the output register in the cycle after the beat;
// a start beat first latches the clipped geometry, then emits the first pixel once the output is free.
// Throughput: one pixel per cycle along a line while the receiver is ready; each line change runs the
// line color divider first (a numerator step, eight radix-2 steps, four channels in parallel).
// Reset (synchronous, active low) clears the config, fill and sequencer state, stops any fill and empties the output.
`timescale 1ns / 1ps

module gradient_rect_fill_unit
  import grf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  grf_in_if.sink     in_if,
  grf_out_if.source  out_if,
  grf_cfg_if.sink    cfg_if
);

  cmd_t  cmd;
  stat_t stat;

  grf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .stat  (stat),
    .cmd   (cmd)
  );

  grf_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .out_if (out_if),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

/* sim/tb_gradient_rect_fill_unit.sv */
// Self-checking testbench for the gradient rectangle fill unit.
`timescale 1ns / 1ps

module tb_gradient_rect_fill_unit;
  import grf_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   alpha;
    logic              last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  grf_in_if  in_if ();
  grf_out_if out_if ();
  grf_cfg_if cfg_if ();

  gradient_rect_fill_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #5 clk = ~clk;

  // Shadow registers and fill state of the predictor
  logic [RECT_W-1:0]  shadow_x = '0, shadow_y = '0, shadow_w = '0, shadow_h = '0;
  logic [COLOR_W-1:0] shadow_c0 = '0, shadow_c1 = '0;
  logic               shadow_vert = 1'b0;
  logic               fill_on = 1'b0;
  int unsigned        outer_i = 0, inner_i = 0;
  int unsigned        clip_x0 = 0, clip_y0 = 0, clip_w = 0, clip_h = 0;
  logic [COLOR_W-1:0] line_col = '0;

  pixel_t expected_pixels[$];
  int     pixel_mismatches = 0;
  int     cycle_count = 0;
  int     src_idle_pct = 0;
  int     snk_idle_pct = 0;
  bit     hold_req = 0;
  int     hold_left = 0;
  bit     quiet = 1;

  // Rectangle as last written by the stimulus
  logic [RECT_W-1:0] cur_x = '0, cur_y = '0, cur_w = '0, cur_h = '0;

  // Clamp the origin to the surface and cut the size only where it overflows
  function automatic void clip_rect(input logic [RECT_W-1:0] rx, ry, rw, rh,
                                    output int x, y, w, h);
    x = $signed(rx);
    y = $signed(ry);
    if (x < 0) x = 0; else if (x > SURF_W) x = SURF_W;
    if (y < 0) y = 0; else if (y > SURF_H) y = SURF_H;
    w = rw;
    h = rh;
    if (x + w > SURF_W) w = SURF_W - x;
    if (y + h > SURF_H) h = SURF_H - y;
  endfunction

  // Per channel (c0*(n-i) + c1*i) / n, truncating
  function automatic logic [COLOR_W-1:0] blend_line(int unsigned i, int unsigned n);
    logic [COLOR_W-1:0] res;
    int unsigned c0, c1;
    res = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      c0 = shadow_c0[k*CH_W +: CH_W];
      c1 = shadow_c1[k*CH_W +: CH_W];
      res[k*CH_W +: CH_W] = CH_W'((c0 * (n - i) + c1 * i) / n);
    end
    return res;
  endfunction

  function automatic void emit_pixel();
    pixel_t px;
    int unsigned on, inn, row, col;
    on  = shadow_vert ? clip_h : clip_w;
    inn = shadow_vert ? clip_w : clip_h;
    if (shadow_vert) begin
      row = clip_y0 + outer_i;
      col = clip_x0 + inner_i;
    end else begin
      row = clip_y0 + inner_i;
      col = clip_x0 + outer_i;
    end
    px.addr  = ADDR_W'(row * SURF_W + col);
    px.red   = line_col[31:24];
    px.green = line_col[23:16];
    px.blue  = line_col[15:8];
    px.alpha = line_col[7:0];
    px.last  = (inner_i + 1 >= inn) && (outer_i + 1 >= on);
    expected_pixels.push_back(px);
    // Advance along the line, recolor on a line change
    if (px.last) begin
      fill_on = 1'b0;
      outer_i = 0;
      inner_i = 0;
    end else begin
      inner_i++;
      if (inner_i >= inn) begin
        inner_i = 0;
        outer_i++;
        line_col = blend_line(outer_i, on);
      end
    end
  endfunction

  function automatic void fill_step(logic start);
    int x, y, w, h;
    if (start) begin
      clip_rect(shadow_x, shadow_y, shadow_w, shadow_h, x, y, w, h);
      clip_x0 = x;
      clip_y0 = y;
      clip_w  = w;
      clip_h  = h;
      outer_i = 0;
      inner_i = 0;
      if (w == 0 || h == 0) begin
        fill_on  = 1'b0;
        line_col = '0;
        return;
      end
      fill_on  = 1'b1;
      line_col = blend_line(0, shadow_vert ? h : w);
      emit_pixel();
    end else if (fill_on) begin
      emit_pixel();
    end
  endfunction

  // Any known register write drops the running fill
  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    case (idx)
      REG_RECT_X:      shadow_x = d[RECT_W-1:0];
      REG_RECT_Y:      shadow_y = d[RECT_W-1:0];
      REG_RECT_W:      shadow_w = d[RECT_W-1:0];
      REG_RECT_H:      shadow_h = d[RECT_W-1:0];
      REG_COLOR_START: shadow_c0 = d;
      REG_COLOR_END:   shadow_c1 = d;
      REG_GRAD_VERT:   shadow_vert = d[0];
      default:         return;
    endcase
    fill_on = 1'b0;
    outer_i = 0;
    inner_i = 0;
  endfunction

  function automatic void compare_channel(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      pixel_mismatches++;
    end
  endfunction

  // Check output beats, then update the predictor from accepted beats
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel beat: expected none, actual address %0h",
                   $time, out_if.pixel_address);
          pixel_mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          compare_channel("pixel_address", want.addr, out_if.pixel_address);
          compare_channel("red", want.red, out_if.red);
          compare_channel("green", want.green, out_if.green);
          compare_channel("blue", want.blue, out_if.blue);
          compare_channel("alpha", want.alpha, out_if.alpha);
          compare_channel("last", want.last, out_if.last);
        end
      end
      if (cfg_if.valid && cfg_if.ready) shadow_write(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) fill_step(in_if.start_req);
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Drop valid, wait for all pixels, then let the line divider finish
  task automatic settle();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    quiet = 1;
  endtask

  task automatic send_item(logic start);
    cfg_if.valid <= 1'b0;
    quiet = 0;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.start_req <= start;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [11:0] val);
    logic [31:0] d;
    if (!quiet) settle();
    d = $urandom();
    d[11:0] = val;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic cfg_write_word(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    if (!quiet) settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic set_rect(int x, int y, int w, int h);
    cur_x = x[11:0];
    cur_y = y[11:0];
    cur_w = w[11:0];
    cur_h = h[11:0];
    cfg_write(REG_RECT_X, cur_x);
    cfg_write(REG_RECT_Y, cur_y);
    cfg_write(REG_RECT_W, cur_w);
    cfg_write(REG_RECT_H, cur_h);
  endtask

  task automatic set_colors(logic [31:0] c0, logic [31:0] c1, logic vert);
    logic [31:0] d;
    cfg_write_word(REG_COLOR_START, c0);
    cfg_write_word(REG_COLOR_END, c1);
    d = $urandom();
    d[0] = vert;
    cfg_write_word(REG_GRAD_VERT, d);
  endtask

  function automatic int fill_pixels();
    int x, y, w, h;
    clip_rect(cur_x, cur_y, cur_w, cur_h, x, y, w, h);
    return w * h;
  endfunction

  // Registers at reset give an empty rectangle; advance while idle
  task automatic test_reset_state();
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // Bottom-right corner clipped to 2x2 in both walking orders
  task automatic test_corner_clip();
    set_rect(1022, 1022, 4095, 4095);
    set_colors(32'hFF00_FF00, 32'h00FF_00FF, 1'b1);
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    cfg_write_word(REG_GRAD_VERT, 32'hFFFF_FFFE);
    send_item(1'b1);
    repeat (4) send_item(1'b0);
  endtask

  // Negative and far origins, zero width, single pixel
  task automatic test_edge_clamp();
    set_rect(-2048, -1, 2, 1);
    set_colors(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_item(1'b1);
    send_item(1'b0);
    set_rect(2047, 0, 0, 4095);
    send_item(1'b1);
    set_rect(1023, 1023, 4095, 4095);
    send_item(1'b1);
  endtask

  // Restart while active, spare index keeps the fill, real write cancels it
  task automatic test_restart_cancel();
    set_rect(0, 0, 4095, 4095);
    set_colors(32'h1234_5678, 32'hFEDC_BA98, 1'b0);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    cfg_write_word(REG_SPARE, $urandom());
    send_item(1'b0);
    cfg_write_word(REG_COLOR_END, 32'h8080_8080);
    send_item(1'b0);
  endtask

  // Hold the receiver off while the sender keeps pushing advances
  task automatic test_backpressure();
    set_rect(100, 200, 16, 16);
    set_colors($urandom(), $urandom(), 1'b1);
    send_item(1'b1);
    hold_req = 1;
    repeat (60) send_item(1'b0);
  endtask

  function automatic int rand_origin();
    case ($urandom_range(9))
      0:       return $urandom_range(1024, 2047);
      1:       return -int'($urandom_range(1, 2048));
      2:       return $urandom_range(1016, 1023);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  function automatic int rand_size();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return 0;
    if (roll < 4) return $urandom_range(0, 4095);
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [31:0] rand_color();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mostly complete fills of small rectangles, some cut short or restarted
  task automatic test_random_fills(int n_items, int src_pct, int snk_pct);
    int sent, fill, adv;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) != 0) begin
        set_rect(rand_origin(), rand_origin(), rand_size(), rand_size());
        if ($urandom_range(1)) begin
          cfg_write_word(REG_COLOR_START, rand_color());
          cfg_write_word(REG_COLOR_END, rand_color());
        end
        if ($urandom_range(1)) cfg_write_word(REG_GRAD_VERT, $urandom());
        if ($urandom_range(9) == 0) cfg_write_word(REG_SPARE, $urandom());
      end
      fill = fill_pixels();
      send_item(1'b1);
      if (fill == 0) adv = $urandom_range(0, 2);
      else if (fill > 64) adv = $urandom_range(1, 64);
      else if ($urandom_range(9) < 7) adv = fill - 1 + $urandom_range(0, 2);
      else adv = (fill > 1) ? $urandom_range(0, fill - 2) : 0;
      repeat (adv) send_item(1'b0);
      sent += 1 + adv;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.start_req = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 34;
    snk_idle_pct = 52;
    test_reset_state();
    test_corner_clip();
    test_edge_clamp();
    test_restart_cancel();
    test_backpressure();
    test_random_fills(650, 34, 52);
    test_random_fills(650, 52, 34);
    test_random_fills(650, 0, 0);

    // Drain and report
    settle();
    if (pixel_mismatches == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/grf_pkg.sv
hdl/grf_ifs.sv
hdl/grf_ctrl.sv
hdl/grf_dp.sv
hdl/gradient_rect_fill_unit.sv
sim/tb_gradient_rect_fill_unit.sv
